[rtl/core/vcc_pkg.sv]
// Shared types, register indexes and constants of the vending coin controller.
`default_nettype none

package vcc_pkg;

   // Default width of the coin counters
   localparam int COUNT_WIDTH_DEF = 8;

   // Product buttons that are wired; a higher index is ignored
   localparam int PRODUCTS = 4;

   localparam int TICK_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRICE_A       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRICE_B       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRICE_C       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRICE_D       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_WAIT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPENSE_WAIT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETURN_WAIT   = 3'd6;

   localparam logic [7:0] PRICE_A_RST       = 8'd30;
   localparam logic [7:0] PRICE_B_RST       = 8'd35;
   localparam logic [7:0] PRICE_C_RST       = 8'd40;
   localparam logic [7:0] PRICE_D_RST       = 8'd45;
   localparam logic [7:0] SHORT_WAIT_RST    = 8'd20;
   localparam logic [7:0] DISPENSE_WAIT_RST = 8'd40;
   localparam logic [7:0] RETURN_WAIT_RST   = 8'd100;

   // Chosen product code meaning no product selected
   localparam logic [2:0] NONE_CHOSEN = 3'd4;

   localparam logic [12:0] PULSE_DOWN = 13'd1000;
   localparam logic [12:0] PULSE_REST = 13'd2850;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_COIN     = 3'd1,
      MODE_COUNT    = 3'd2,
      MODE_SHORT    = 3'd3,
      MODE_DISPENSE = 3'd4,
      MODE_DONE     = 3'd5,
      MODE_CHANGE   = 3'd6,
      MODE_RETURN   = 3'd7
   } mode_type;

   typedef struct packed {
      logic [3:0][7:0] price;
      logic [7:0]      short_wait;
      logic [7:0]      dispense_wait;
      logic [7:0]      return_wait;
   } cfg_type;

   typedef struct packed {
      logic       coin_twenty;
      logic       coin_five;
      logic       return_press;
      logic       product_press;
      logic [1:0] product_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  mode_code;
      logic [12:0] credit_cents;
      logic [7:0]  twenty_count;
      logic [7:0]  five_count;
      logic [12:0] servo_pulse;
      logic [3:0]  led_pattern;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/vcc_csr.sv]
// Configuration register file: prices and wait times.
`default_nettype none

module vcc_csr
   import vcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PRICE_A:       cfg_in.price[0]      = csr_wdata;
            CSR_PRICE_B:       cfg_in.price[1]      = csr_wdata;
            CSR_PRICE_C:       cfg_in.price[2]      = csr_wdata;
            CSR_PRICE_D:       cfg_in.price[3]      = csr_wdata;
            CSR_SHORT_WAIT:    cfg_in.short_wait    = csr_wdata;
            CSR_DISPENSE_WAIT: cfg_in.dispense_wait = csr_wdata;
            CSR_RETURN_WAIT:   cfg_in.return_wait   = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.price[0]      <= PRICE_A_RST;
         cfg_ff.price[1]      <= PRICE_B_RST;
         cfg_ff.price[2]      <= PRICE_C_RST;
         cfg_ff.price[3]      <= PRICE_D_RST;
         cfg_ff.short_wait    <= SHORT_WAIT_RST;
         cfg_ff.dispense_wait <= DISPENSE_WAIT_RST;
         cfg_ff.return_wait   <= RETURN_WAIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/core/vcc_change.sv]
// Change maker: splits a credit into the most 20c coins, then 5c, with clamped counts.
`default_nettype none

module vcc_change #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic [COUNT_WIDTH+4:0] credit,
   output logic [COUNT_WIDTH-1:0] twenties,
   output logic [COUNT_WIDTH-1:0] fives
);

   // credit / 20 = (credit >> 2) / 5, by an exact reciprocal over the range of x
   localparam int XW = COUNT_WIDTH + 3;
   localparam int KS = XW + 3;
   localparam int MW = KS - 2;
   localparam int QW = COUNT_WIDTH + 1;
   localparam logic [MW-1:0] RECIP = MW'((2 ** KS + 4) / 5);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic [XW-1:0]    x;
   logic [XW+MW-1:0] prod;
   logic [QW-1:0]    q;
   logic [XW-1:0]    q_times5;
   logic [2:0]       r5;
   logic [4:0]       r20;
   logic [1:0]       f_lo;
   logic [QW-1:0]    excess;
   logic [QW+1:0]    f_sum;

   assign x        = credit[COUNT_WIDTH+4:2];
   assign prod     = (XW+MW)'(x) * (XW+MW)'(RECIP);
   assign q        = prod[XW+MW-1:KS];
   assign q_times5 = XW'({q, 2'b00}) + XW'(q);
   assign r5       = 3'(x - q_times5);
   assign r20      = {r5, credit[1:0]};

   // Fives from the remainder below 20
   always_comb begin
      if (r20 >= 5'd15) begin
         f_lo = 2'd3;
      end else if (r20 >= 5'd10) begin
         f_lo = 2'd2;
      end else if (r20 >= 5'd5) begin
         f_lo = 2'd1;
      end else begin
         f_lo = 2'd0;
      end
   end

   assign excess = q - QW'(CNT_MAX);
   assign f_sum  = {excess, 2'b00} + (QW+2)'(f_lo);

   // Twenties past full spill four fives each
   always_comb begin
      if (q[COUNT_WIDTH]) begin
         twenties = CNT_MAX;
         if (f_sum > (QW+2)'(CNT_MAX)) begin
            fives = CNT_MAX;
         end else begin
            fives = f_sum[COUNT_WIDTH-1:0];
         end
      end else begin
         twenties = q[COUNT_WIDTH-1:0];
         fives    = COUNT_WIDTH'(f_lo);
      end
   end

endmodule

`default_nettype wire

[rtl/core/vcc_step.sv]
// Next-state logic for one tick word: mode, counters, credit, servo and LEDs.
`default_nettype none

module vcc_step
   import vcc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  cfg_type                cfg,
   input  req_type                item,
   input  mode_type               mode,
   input  logic [TICK_W-1:0]      tick,
   input  logic [COUNT_WIDTH+4:0] credit,
   input  logic [COUNT_WIDTH-1:0] twenties,
   input  logic [COUNT_WIDTH-1:0] fives,
   input  logic [2:0]             chosen,
   input  logic                   servo_down,
   input  logic [3:0]             leds,
   output mode_type               mode_n,
   output logic [TICK_W-1:0]      tick_n,
   output logic [COUNT_WIDTH+4:0] credit_n,
   output logic [COUNT_WIDTH-1:0] twenties_n,
   output logic [COUNT_WIDTH-1:0] fives_n,
   output logic [2:0]             chosen_n,
   output logic                   servo_down_n,
   output logic [3:0]             leds_n
);

   localparam int CRW = COUNT_WIDTH + 5;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
   localparam logic [TICK_W-1:0]      TICK_MAX = '1;

   logic [TICK_W-1:0]      tick_inc;
   logic [COUNT_WIDTH-1:0] chg_twenties;
   logic [COUNT_WIDTH-1:0] chg_fives;
   logic                   prod_ok;
   logic [7:0]             disp_price;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [CRW-1:0] coin_credit(input logic [COUNT_WIDTH-1:0] t,
                                                  input logic [COUNT_WIDTH-1:0] f);
      return (CRW'(t) << 4) + (CRW'(t) << 2) + (CRW'(f) << 2) + CRW'(f);
   endfunction

   vcc_change #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_change (
      .credit   (credit),
      .twenties (chg_twenties),
      .fives    (chg_fives)
   );

   assign tick_inc   = (tick == TICK_MAX) ? tick : tick + 1'b1;
   assign prod_ok    = item.product_press && (4'(item.product_index) < 4'(PRODUCTS));
   assign disp_price = chosen[2] ? 8'd0 : cfg.price[chosen[1:0]];

   always_comb begin
      mode_n       = mode;
      tick_n       = tick_inc;
      credit_n     = credit;
      twenties_n   = twenties;
      fives_n      = fives;
      chosen_n     = chosen;
      servo_down_n = servo_down;
      leds_n       = leds;
      unique case (mode)
         MODE_IDLE: begin
            if (item.coin_twenty) begin
               twenties_n = sat_inc(twenties);
               credit_n   = coin_credit(twenties_n, fives);
               mode_n     = MODE_COIN;
               tick_n     = '0;
            end else if (item.coin_five) begin
               fives_n  = sat_inc(fives);
               credit_n = coin_credit(twenties, fives_n);
               mode_n   = MODE_COIN;
               tick_n   = '0;
            end
         end
         MODE_COIN: begin
            if (tick_inc >= cfg.short_wait) begin
               mode_n = MODE_COUNT;
            end
         end
         MODE_COUNT: begin
            if (item.coin_twenty) begin
               twenties_n = sat_inc(twenties);
               mode_n     = MODE_COIN;
               tick_n     = '0;
            end else if (item.coin_five) begin
               fives_n = sat_inc(fives);
               mode_n  = MODE_COIN;
               tick_n  = '0;
            end else if (item.return_press) begin
               twenties_n = chg_twenties;
               fives_n    = chg_fives;
               mode_n     = MODE_RETURN;
               tick_n     = '0;
            end else if (prod_ok) begin
               chosen_n = {1'b0, item.product_index};
            end
            // A selection overrides the mode; compare against the credit held so far
            if (!chosen_n[2]) begin
               if (credit >= CRW'(cfg.price[chosen_n[1:0]])) begin
                  mode_n       = MODE_DISPENSE;
                  servo_down_n = 1'b1;
                  leds_n       = 4'b1000 >> chosen_n[1:0];
               end else begin
                  mode_n = MODE_SHORT;
               end
               tick_n = '0;
            end
            credit_n = coin_credit(twenties_n, fives_n);
         end
         MODE_SHORT: begin
            if (tick_inc >= cfg.short_wait) begin
               tick_n   = '0;
               mode_n   = MODE_COUNT;
               chosen_n = NONE_CHOSEN;
            end
         end
         MODE_DISPENSE: begin
            if (tick_inc >= cfg.dispense_wait) begin
               credit_n     = (credit >= CRW'(disp_price)) ? credit - CRW'(disp_price) : '0;
               servo_down_n = 1'b0;
               leds_n       = '0;
               mode_n       = MODE_DONE;
               tick_n       = '0;
            end
         end
         MODE_DONE: begin
            if (tick_inc >= cfg.dispense_wait) begin
               twenties_n = chg_twenties;
               fives_n    = chg_fives;
               mode_n     = MODE_CHANGE;
               tick_n     = '0;
            end
         end
         MODE_CHANGE: begin
            if (tick_inc >= cfg.short_wait) begin
               mode_n = MODE_RETURN;
            end
         end
         MODE_RETURN: begin
            if (tick_inc >= cfg.return_wait) begin
               mode_n     = MODE_IDLE;
               twenties_n = '0;
               fives_n    = '0;
               credit_n   = '0;
               chosen_n   = NONE_CHOSEN;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/vending_coin_controller.sv]
// Top level of the vending coin controller: input register, state, result register.
//
// Usage:
//   req_*  carries one word per 50 ms tick: the sampled coin, return and product
//          buttons. rsp_* returns one word per tick: mode, credit, coin counts,
//          servo pulse width and product LED pattern after that tick's update.
//   csr_*  writes prices and wait times; write only while no tick is in flight.
// Path: a tick word accepted into the input register is evaluated against the
//   state and, once the result slot is free or being drained, written to rsp_data
//   together with the state registers.
// Throughput: one word per cycle while rsp_ready is high; the whole tick update
//   is one pass of combinational logic between the input register and the state
//   and result registers, with one reciprocal multiply for the change split.
// Reset: synchronous; mode idle, credit and counts zero, servo at rest, LEDs
//   off, prices and waits back to their defaults, both channels empty.
// Stall: while rsp_ready is low the result holds; one more word is taken into
//   the input register, then req_ready drops until the result moves on.
`default_nettype none

module vending_coin_controller
   import vcc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CRW = COUNT_WIDTH + 5;

   cfg_type cfg;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    req_fire;
   logic    advance;

   mode_type               mode_ff;
   mode_type               mode_in;
   logic [TICK_W-1:0]      tick_ff;
   logic [TICK_W-1:0]      tick_in;
   logic [CRW-1:0]         credit_ff;
   logic [CRW-1:0]         credit_in;
   logic [COUNT_WIDTH-1:0] twenties_ff;
   logic [COUNT_WIDTH-1:0] twenties_in;
   logic [COUNT_WIDTH-1:0] fives_ff;
   logic [COUNT_WIDTH-1:0] fives_in;
   logic [2:0]             chosen_ff;
   logic [2:0]             chosen_in;
   logic                   servo_ff;
   logic                   servo_in;
   logic [3:0]             leds_ff;
   logic [3:0]             leds_in;

   vcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vcc_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .cfg          (cfg),
      .item         (in_data_ff),
      .mode         (mode_ff),
      .tick         (tick_ff),
      .credit       (credit_ff),
      .twenties     (twenties_ff),
      .fives        (fives_ff),
      .chosen       (chosen_ff),
      .servo_down   (servo_ff),
      .leds         (leds_ff),
      .mode_n       (mode_in),
      .tick_n       (tick_in),
      .credit_n     (credit_in),
      .twenties_n   (twenties_in),
      .fives_n      (fives_in),
      .chosen_n     (chosen_in),
      .servo_down_n (servo_in),
      .leds_n       (leds_in)
   );

   // Advance the held word whenever the result slot is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      rsp_data_in.mode_code    = 3'(mode_in);
      rsp_data_in.credit_cents = 13'(credit_in);
      rsp_data_in.twenty_count = 8'(twenties_in);
      rsp_data_in.five_count   = 8'(fives_in);
      rsp_data_in.servo_pulse  = servo_in ? PULSE_DOWN : PULSE_REST;
      rsp_data_in.led_pattern  = leds_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         tick_ff      <= '0;
         credit_ff    <= '0;
         twenties_ff  <= '0;
         fives_ff     <= '0;
         chosen_ff    <= NONE_CHOSEN;
         servo_ff     <= 1'b0;
         leds_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff     <= mode_in;
            tick_ff     <= tick_in;
            credit_ff   <= credit_in;
            twenties_ff <= twenties_in;
            fives_ff    <= fives_in;
            chosen_ff   <= chosen_in;
            servo_ff    <= servo_in;
            leds_ff     <= leds_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/core/vcc_checker.sv]
// Port-level checks of the vending coin controller and their bind.
`default_nettype none

module vcc_checker
   import vcc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Result channel comes up empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Servo is down exactly while dispensing, with one product LED lit
   a_servo_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.servo_pulse == PULSE_DOWN) ==
                     (rsp_data.mode_code == MODE_DISPENSE)) &&
                    ((rsp_data.led_pattern != 4'd0) ==
                     (rsp_data.mode_code == MODE_DISPENSE)) &&
                    $onehot0(rsp_data.led_pattern))
      else $error("servo, LEDs and dispensing mode disagree");

   // Idle means nothing is owed
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.mode_code == MODE_IDLE) |->
         (rsp_data.credit_cents == 13'd0) && (rsp_data.twenty_count == 8'd0) &&
         (rsp_data.five_count == 8'd0))
      else $error("credit or coin count left over in idle");

endmodule

bind vending_coin_controller vcc_checker u_vcc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
